// ===== hdl/stop_pkg.sv =====
// Shared types, constants and register indexes of the sprite tone and opacity pixel block.
package stop_pkg;

	localparam int MAX_DIM_DEF   = 4096;
	localparam int Q_DEPTH_DEF   = 4;
	localparam int OUT_DEPTH_DEF = 16;
	localparam int PIPE_D        = 8;

	localparam int CH_W   = 8;
	localparam int TONE_W = 9;
	localparam int DIM_W  = 13;
	localparam int CFG_W  = 13;
	localparam int LUMA_W = 24;

	localparam logic [15:0] LUMA_K0 = 16'd19595;
	localparam logic [15:0] LUMA_K1 = 16'd38470;
	localparam logic [15:0] LUMA_K2 = 16'd7471;

	typedef enum logic [2:0] {
		REG_TONE_RED   = 3'd0,
		REG_TONE_GREEN = 3'd1,
		REG_TONE_BLUE  = 3'd2,
		REG_TONE_GRAY  = 3'd3,
		REG_OPACITY    = 3'd4,
		REG_HALVE_ROWS = 3'd5,
		REG_WIDTH      = 3'd6,
		REG_HEIGHT     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0] halve_rows;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} front_cfg_t;

	typedef struct packed {
		logic signed [2:0][TONE_W-1:0] tone;
		logic [CH_W-1:0]               tone_gray;
		logic [CH_W-1:0]               opacity;
	} back_cfg_t;

	typedef struct packed {
		logic [2:0][CH_W-1:0] chan;
		logic [CH_W-1:0]      alpha;
		logic                 bush;
		logic                 eoi;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0] out_0;
		logic [CH_W-1:0] out_1;
		logic [CH_W-1:0] out_2;
		logic [CH_W-1:0] alpha_out;
		logic            end_of_image;
	} res_t;

	typedef struct packed {
		logic [LUMA_W-1:0] luma;
		logic [CH_W-1:0]   alpha;
		logic              eoi;
	} side_t;

endpackage

// ===== hdl/stop_in_if.sv =====
// Input pixel channel: valid, ready and one RGBA pixel.
interface stop_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] chan_0;
	logic [7:0] chan_1;
	logic [7:0] chan_2;
	logic [7:0] alpha_in;

	modport source(output valid, output chan_0, output chan_1, output chan_2,
		output alpha_in, input ready);
	modport sink(input valid, input chan_0, input chan_1, input chan_2,
		input alpha_in, output ready);
endinterface

// ===== hdl/stop_out_if.sv =====
// Result pixel channel: valid, ready and one toned pixel with end-of-image flag.
interface stop_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_0;
	logic [7:0] out_1;
	logic [7:0] out_2;
	logic [7:0] alpha_out;
	logic       end_of_image;

	modport source(output valid, output out_0, output out_1, output out_2,
		output alpha_out, output end_of_image, input ready);
	modport sink(input valid, input out_0, input out_1, input out_2,
		input alpha_out, input end_of_image, output ready);
endinterface

// ===== hdl/sprite_tone_opacity_pixel.sv =====
// Top level of the sprite tone and opacity pixel block: config registers and stage wiring.
//
//   channel   dir   handshake          beat
//   pix       in    valid/ready        chan_0, chan_1, chan_2, alpha_in
//   res       out   valid/ready        out_0, out_1, out_2, alpha_out, end_of_image
//   cfg       in    cfg_we (no wait)   cfg_idx, cfg_data
//
// One pixel per clock sustained while the result side keeps taking beats; a pixel passes
// through the front queue, then the 8-stage back pipeline, then the output queue.
// The back pipeline pulls from the front queue only while the output queue has room
// for everything in flight, so either side may stall freely.
// Reset clears counters, queues and config to their defaults.
module sprite_tone_opacity_pixel import stop_pkg::*; #(
	parameter int MAX_DIM   = MAX_DIM_DEF,
	parameter int Q_DEPTH   = Q_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	stop_in_if.sink          pix,
	stop_out_if.source       res,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int QAW = $clog2(Q_DEPTH);
	localparam int OAW = $clog2(OUT_DEPTH);

	front_cfg_t fcfg_q;
	back_cfg_t  bcfg_q;

	logic          q_push, q_pop, q_full, q_empty;
	logic [QAW:0]  q_count;
	item_t         q_wr, q_rd;
	logic [$bits(item_t)-1:0] q_rdata;

	logic          o_push, o_pop, o_full, o_empty;
	logic [OAW:0]  o_count;
	res_t          o_wr, o_rd;
	logic [$bits(res_t)-1:0] o_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcfg_q.tone      <= '0;
			bcfg_q.tone_gray <= '0;
			bcfg_q.opacity   <= 8'd255;
			fcfg_q.halve_rows   <= '0;
			fcfg_q.image_width  <= DIM_W'(1);
			fcfg_q.image_height <= DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				REG_TONE_RED:   bcfg_q.tone[0]      <= cfg_data[TONE_W-1:0];
				REG_TONE_GREEN: bcfg_q.tone[1]      <= cfg_data[TONE_W-1:0];
				REG_TONE_BLUE:  bcfg_q.tone[2]      <= cfg_data[TONE_W-1:0];
				REG_TONE_GRAY:  bcfg_q.tone_gray    <= cfg_data[CH_W-1:0];
				REG_OPACITY:    bcfg_q.opacity      <= cfg_data[CH_W-1:0];
				REG_HALVE_ROWS: fcfg_q.halve_rows   <= cfg_data[DIM_W-1:0];
				REG_WIDTH:      fcfg_q.image_width  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:     fcfg_q.image_height <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	stop_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (fcfg_q),
		.pix    (pix),
		.q_full (q_full),
		.q_push (q_push),
		.q_item (q_wr)
	);

	stop_fifo #(.DEPTH(Q_DEPTH), .W($bits(item_t))) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wr),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty),
		.count  (q_count)
	);

	assign q_rd = item_t'(q_rdata);

	stop_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (bcfg_q),
		.in_empty  (q_empty),
		.in_item   (q_rd),
		.in_pop    (q_pop),
		.out_count (o_count),
		.out_push  (o_push),
		.out_res   (o_wr)
	);

	stop_fifo #(.DEPTH(OUT_DEPTH), .W($bits(res_t))) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (o_push && !o_full),
		.wdata  (o_wr),
		.pop    (o_pop),
		.rdata  (o_rdata),
		.full   (o_full),
		.empty  (o_empty),
		.count  (o_count)
	);

	assign o_rd  = res_t'(o_rdata);
	assign o_pop = !o_empty && res.ready;

	assign res.valid        = !o_empty;
	assign res.out_0        = o_rd.out_0;
	assign res.out_1        = o_rd.out_1;
	assign res.out_2        = o_rd.out_2;
	assign res.alpha_out    = o_rd.alpha_out;
	assign res.end_of_image = o_rd.end_of_image && (q_count <= (QAW+1)'(Q_DEPTH));

endmodule

// ===== hdl/stop_fifo.sv =====
// Small synchronous FIFO with show-ahead read and fill count.
module stop_fifo #(
	parameter int DEPTH = 4,
	parameter int W     = 8,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [W-1:0]  wdata,
	input  logic          pop,
	output logic [W-1:0]  rdata,
	output logic          full,
	output logic          empty,
	output logic [AW:0]   count
);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign rdata = mem_q[rd_q];
	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

endmodule

// ===== hdl/stop_front.sv =====
// Front end: accepts pixels, tracks column and row, tags bush rows and end of image.
module stop_front import stop_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
	localparam int EW = ($clog2(MAX_DIM + 1) > DIM_W) ? $clog2(MAX_DIM + 1) : DIM_W
) (
	input  logic       clk,
	input  logic       arst_n,
	input  front_cfg_t cfg,
	stop_in_if.sink    pix,
	input  logic       q_full,
	output logic       q_push,
	output item_t      q_item
);

	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [EW-1:0] w_eff;
	logic [EW-1:0] h_eff;
	logic [EW-1:0] bush_x;
	logic [EW-1:0] halve_from;
	logic          last_col;
	logic          last_row;

	always_comb begin
		w_eff = EW'(cfg.image_width);
		if (cfg.image_width == '0) begin
			w_eff = EW'(1);
		end else if (EW'(cfg.image_width) > EW'(MAX_DIM)) begin
			w_eff = EW'(MAX_DIM);
		end
		h_eff = EW'(cfg.image_height);
		if (cfg.image_height == '0) begin
			h_eff = EW'(1);
		end else if (EW'(cfg.image_height) > EW'(MAX_DIM)) begin
			h_eff = EW'(MAX_DIM);
		end
		bush_x     = EW'(cfg.halve_rows);
		halve_from = (h_eff > bush_x) ? (h_eff - bush_x) : '0;
		last_col   = (EW'(col_q) + EW'(1)) >= w_eff;
		last_row   = (EW'(row_q) + EW'(1)) >= h_eff;
	end

	assign pix.ready = !q_full;
	assign q_push    = pix.valid && !q_full;

	always_comb begin
		q_item.chan[0] = pix.chan_0;
		q_item.chan[1] = pix.chan_1;
		q_item.chan[2] = pix.chan_2;
		q_item.alpha   = pix.alpha_in;
		q_item.bush    = EW'(row_q) >= halve_from;
		q_item.eoi     = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ===== hdl/stop_back.sv =====
// Back end: luma desaturation, tone offset, clamp and alpha scaling pipeline.
module stop_back import stop_pkg::*; #(
	parameter int OUT_DEPTH = OUT_DEPTH_DEF,
	localparam int OCW = $clog2(OUT_DEPTH) + 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  back_cfg_t      cfg,
	input  logic           in_empty,
	input  item_t          in_item,
	output logic           in_pop,
	input  logic [OCW-1:0] out_count,
	output logic           out_push,
	output res_t           out_res
);

	logic [PIPE_D-1:0] vld_q;
	logic [OCW:0]      used;

	logic [LUMA_W-1:0] luma_c;
	logic [CH_W-1:0]   a_half;
	logic [15:0]       aprod;
	logic [16:0]       adiv;
	logic [CH_W:0]     kgray;

	logic [CH_W-1:0]     c_s1 [3];
	side_t               side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic signed [24:0]  diff_s2 [3];
	logic signed [33:0]  n_s3 [3];
	logic [32:0]         m_s4 [3];
	logic                neg_s4 [3];
	logic [32:0]         m_s5 [3];
	logic [25:0]         q_s5 [3];
	logic                neg_s5 [3];
	logic [25:0]         q_s6 [3];
	logic [9:0]          r_s6 [3];
	logic                neg_s6 [3];
	logic signed [26:0]  qs_s7 [3];
	logic signed [27:0]  v_s8 [3];
	side_t               side_s8;

	logic signed [33:0]  nn [3];
	logic [33:0]         ssum [3];
	logic [25:0]         qf [3];
	logic signed [27:0]  qs_x [3];
	logic signed [27:0]  tone_x [3];
	logic [CH_W-1:0]     clamp [3];

	// keep room in the output queue for every beat in flight
	always_comb begin
		used   = (OCW+1)'(out_count) + (OCW+1)'($countones(vld_q));
		in_pop = !in_empty && (used < (OCW+1)'(OUT_DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_D-2:0], in_pop};
		end
	end

	always_comb begin
		luma_c = LUMA_K0 * LUMA_W'(in_item.chan[0]) + LUMA_K1 * LUMA_W'(in_item.chan[1])
			+ LUMA_K2 * LUMA_W'(in_item.chan[2]);
		a_half = in_item.bush ? (in_item.alpha >> 1) : in_item.alpha;
		aprod  = 16'(a_half) * 16'(cfg.opacity);
		adiv   = 17'(aprod) + 17'(aprod >> 8) + 17'd1;
		kgray  = {1'b0, ~cfg.tone_gray};
		for (int i = 0; i < 3; i++) begin
			nn[i]     = 34'sd254 - n_s3[i];
			ssum[i]   = 34'(m_s4[i]) + 34'(m_s4[i] >> 8) + 34'(m_s4[i] >> 16)
				+ 34'(m_s4[i] >> 24) + 34'(m_s4[i] >> 32);
			qf[i]     = q_s6[i] + ((r_s6[i] >= 10'd255) ? 26'd1 : 26'd0);
			qs_x[i]   = 28'(qs_s7[i]);
			tone_x[i] = 28'($signed({cfg.tone[i], 16'b0}));
			if (v_s8[i][27]) begin
				clamp[i] = '0;
			end else if (|v_s8[i][27:24]) begin
				clamp[i] = '1;
			end else begin
				clamp[i] = v_s8[i][23:16];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s1.luma  <= luma_c;
		side_s1.alpha <= adiv[15:8];
		side_s1.eoi   <= in_item.eoi;
		side_s2 <= side_s1;
		side_s3 <= side_s2;
		side_s4 <= side_s3;
		side_s5 <= side_s4;
		side_s6 <= side_s5;
		side_s7 <= side_s6;
		side_s8 <= side_s7;
		for (int i = 0; i < 3; i++) begin
			c_s1[i]    <= in_item.chan[i];
			diff_s2[i] <= $signed({1'b0, c_s1[i], 16'b0}) - $signed({1'b0, side_s1.luma});
			n_s3[i]    <= diff_s2[i] * $signed(kgray);
			neg_s4[i]  <= n_s3[i][33];
			m_s4[i]    <= n_s3[i][33] ? nn[i][32:0] : n_s3[i][32:0];
			m_s5[i]    <= m_s4[i];
			q_s5[i]    <= ssum[i][33:8];
			neg_s5[i]  <= neg_s4[i];
			q_s6[i]    <= q_s5[i];
			r_s6[i]    <= 10'({1'b0, m_s5[i]} - ({q_s5[i], 8'b0} - 34'(q_s5[i])));
			neg_s6[i]  <= neg_s5[i];
			qs_s7[i]   <= neg_s6[i] ? -$signed({1'b0, qf[i]}) : $signed({1'b0, qf[i]});
			v_s8[i]    <= qs_x[i] + $signed(28'(side_s7.luma)) + tone_x[i] + 28'sd32768;
		end
	end

	assign out_push = vld_q[PIPE_D-1];

	always_comb begin
		out_res.out_0        = clamp[0];
		out_res.out_1        = clamp[1];
		out_res.out_2        = clamp[2];
		out_res.alpha_out    = side_s8.alpha;
		out_res.end_of_image = side_s8.eoi;
	end

endmodule

// ===== tb/tone_alpha_checker.sv =====
// Checker for the sprite tone/opacity block: predicts each result beat from input beats and compares.
module tone_alpha_checker
	import stop_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	stop_in_if               pix,
	stop_out_if              res,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_idx,
	input  logic [CFG_W-1:0] cfg_data,
	output int               mismatches,
	output int               pending,
	output int               results_seen,
	output int               images_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [TONE_W-1:0] tone_r, tone_g, tone_b;
	logic [CH_W-1:0]          gray, opac;
	logic [DIM_W-1:0]         bush, wid, hgt;
	int                       col, row, fails, seen, images;
	res_t                     expected_px[$];

	function automatic int clamp_dim(input logic [DIM_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > MAX_DIM_DEF)
			return MAX_DIM_DEF;
		return int'(d);
	endfunction

	// Q16 desaturate, tone offset, round and clamp; all divisions floor
	function automatic logic [CH_W-1:0] tone_byte(input int c, input longint luma,
		input int tone, input int g);
		longint mixed, v;
		mixed = (longint'(c) * 65536 - luma) * (255 - g);
		if (mixed >= 0)
			v = mixed / 255;
		else
			v = -((-mixed + 254) / 255);
		v = v + luma + longint'(tone) * 65536 + 32768;
		if (v < 0)
			return '0;
		v = v / 65536;
		if (v > 255)
			return 8'd255;
		return v[CH_W-1:0];
	endfunction

	function automatic res_t shade_pixel(input logic [CH_W-1:0] c0, c1, c2, a);
		res_t   r;
		int     w, h, bush_row, alpha;
		longint luma;
		w = clamp_dim(wid);
		h = clamp_dim(hgt);
		luma = longint'(LUMA_K0) * c0 + longint'(LUMA_K1) * c1 + longint'(LUMA_K2) * c2;
		bush_row = (h > int'(bush)) ? h - int'(bush) : 0;
		alpha = int'(a);
		if (row >= bush_row)
			alpha = alpha >> 1;
		alpha = alpha * int'(opac) / 255;
		r.out_0 = tone_byte(int'(c0), luma, tone_r, int'(gray));
		r.out_1 = tone_byte(int'(c1), luma, tone_g, int'(gray));
		r.out_2 = tone_byte(int'(c2), luma, tone_b, int'(gray));
		r.alpha_out = alpha[CH_W-1:0];
		r.end_of_image = (col + 1 >= w) && (row + 1 >= h);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		res_t want;
		if (!arst_n) begin
			tone_r = '0;
			tone_g = '0;
			tone_b = '0;
			gray = '0;
			opac = 8'd255;
			bush = '0;
			wid = DIM_W'(1);
			hgt = DIM_W'(1);
			col = 0;
			row = 0;
			fails = 0;
			seen = 0;
			images = 0;
			expected_px.delete();
		end else begin
			if (pix.valid && pix.ready) begin
				expected_px.push_back(shade_pixel(pix.chan_0, pix.chan_1, pix.chan_2,
					pix.alpha_in));
				if (col + 1 >= clamp_dim(wid)) begin
					col = 0;
					row = (row + 1 >= clamp_dim(hgt)) ? 0 : row + 1;
				end else begin
					col++;
				end
			end
			if (res.valid && res.ready) begin
				seen++;
				if (res.end_of_image)
					images++;
				if (expected_px.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected result beat %0d %0d %0d a=%0d eoi=%0b",
							$realtime, res.out_0, res.out_1, res.out_2, res.alpha_out,
							res.end_of_image);
				end else begin
					want = expected_px.pop_front();
					if (res.out_0 !== want.out_0 || res.out_1 !== want.out_1 ||
						res.out_2 !== want.out_2 || res.alpha_out !== want.alpha_out ||
						res.end_of_image !== want.end_of_image) begin
						fails++;
						if (fails <= 10)
							$display({"%0t: beat %0d exp %0d %0d %0d a=%0d eoi=%0b, ",
								"got %0d %0d %0d a=%0d eoi=%0b"},
								$realtime, seen, want.out_0, want.out_1, want.out_2,
								want.alpha_out, want.end_of_image, res.out_0, res.out_1,
								res.out_2, res.alpha_out, res.end_of_image);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					REG_TONE_RED:   tone_r = cfg_data[TONE_W-1:0];
					REG_TONE_GREEN: tone_g = cfg_data[TONE_W-1:0];
					REG_TONE_BLUE:  tone_b = cfg_data[TONE_W-1:0];
					REG_TONE_GRAY:  gray = cfg_data[CH_W-1:0];
					REG_OPACITY:    opac = cfg_data[CH_W-1:0];
					REG_HALVE_ROWS: bush = cfg_data[DIM_W-1:0];
					REG_WIDTH:      wid = cfg_data[DIM_W-1:0];
					REG_HEIGHT:     hgt = cfg_data[DIM_W-1:0];
					default:        ;
				endcase
			end
		end
		mismatches <= fails;
		pending <= expected_px.size();
		results_seen <= seen;
		images_seen <= images;
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives pixels, register writes and output stalls, and reports the verdict.
module tb import stop_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_PIXELS = 700;
	localparam int HOLD_CYCLES   = 120;

	logic             clk, arst_n, cfg_we;
	logic [2:0]       cfg_idx;
	logic [CFG_W-1:0] cfg_data;
	int               mismatches, pending, results_seen, images_seen;
	int               phases;
	bit               quiet, hold_pending;

	stop_in_if  pix_if();
	stop_out_if res_if();

	sprite_tone_opacity_pixel DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_if),
		.res(res_if),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	tone_alpha_checker tone_check (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_if),
		.res(res_if),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending),
		.results_seen(results_seen),
		.images_seen(images_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side: random back-pressure plus one long hold-off
	initial begin : receiver
		int  hold;
		bit  hold_used;
		hold = 0;
		hold_used = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending && !hold_used) begin
				hold = HOLD_CYCLES;
				hold_used = 1;
			end
			if (hold > 0) begin
				hold--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= quiet || ($urandom_range(99) >= 15);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
				idle = 0;
			else
				idle++;
		end
		$display("no beat accepted for %0d cycles", STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic int pick_tone();
		case ($urandom_range(9))
			0:       return -256;
			1:       return -255;
			2:       return 255;
			3:       return 0;
			default: return int'($urandom_range(511)) - 256;
		endcase
	endfunction

	task automatic put_reg(input cfg_idx_t idx, input int val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(posedge clk);
	endtask

	task automatic program_regs(input int t0, t1, t2, gray, opac, bush, wid, hgt);
		put_reg(REG_TONE_RED, t0);
		put_reg(REG_TONE_GREEN, t1);
		put_reg(REG_TONE_BLUE, t2);
		put_reg(REG_TONE_GRAY, gray);
		put_reg(REG_OPACITY, opac);
		put_reg(REG_HALVE_ROWS, bush);
		put_reg(REG_WIDTH, wid);
		put_reg(REG_HEIGHT, hgt);
		cfg_we <= 1'b0;
		phases++;
	endtask

	task automatic send_pixel(input int c0, c1, c2, a);
		while (!quiet && $urandom_range(99) < 15) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.chan_0 <= c0[7:0];
		pix_if.chan_1 <= c1[7:0];
		pix_if.chan_2 <= c2[7:0];
		pix_if.alpha_in <= a[7:0];
		@(posedge clk);
		while (!pix_if.ready)
			@(posedge clk);
	endtask

	task automatic random_pixels(input int n);
		repeat (n)
			send_pixel(int'(pick_byte()), int'(pick_byte()), int'(pick_byte()),
				int'(pick_byte()));
	endtask

	// wait until every predicted beat has come back
	task automatic drain();
		pix_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	initial begin : stimulus
		int sent, n, w, h, d;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_TONE_RED;
		cfg_data = '0;
		pix_if.valid = 1'b0;
		pix_if.chan_0 = '0;
		pix_if.chan_1 = '0;
		pix_if.chan_2 = '0;
		pix_if.alpha_in = '0;
		quiet = 0;
		hold_pending = 0;
		phases = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: 1x1 image, no tone, full opacity
		send_pixel(0, 0, 0, 0);
		send_pixel(255, 255, 255, 255);
		drain();

		// extreme tones incl. -256 pattern, zero width, bush deeper than image
		program_regs(255, -255, -256, 0, 128, 4096, 0, 3);
		send_pixel(255, 0, 128, 255);
		send_pixel(0, 255, 255, 1);
		send_pixel(1, 1, 254, 254);
		drain();

		// full gray, zero opacity, bottom row halved
		program_regs(0, 0, 0, 255, 0, 1, 3, 2);
		send_pixel(255, 0, 0, 200);
		send_pixel(0, 255, 0, 255);
		send_pixel(0, 0, 255, 255);
		send_pixel(255, 255, 255, 128);
		send_pixel(0, 0, 0, 3);
		send_pixel(170, 85, 170, 85);
		drain();

		// partial gray, stop mid image
		program_regs(-1, 1, 100, 128, 255, 2, 2, 4);
		send_pixel(170, 85, 170, 85);
		send_pixel(85, 170, 85, 170);
		send_pixel(255, 0, 255, 0);
		send_pixel(0, 255, 0, 255);
		send_pixel(200, 100, 50, 201);
		drain();

		// shrink size with counters past the new bounds
		program_regs(0, -128, 127, 64, 200, 0, 1, 2);
		send_pixel(12, 34, 56, 78);
		send_pixel(255, 255, 0, 255);
		send_pixel(0, 0, 255, 2);
		drain();

		// width above the dimension limit
		program_regs(pick_tone(), pick_tone(), pick_tone(), int'(pick_byte()),
			int'(pick_byte()), 0, 8191, 1);
		random_pixels(40);
		drain();

		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			case ($urandom_range(9))
				0:       w = 0;
				1:       w = $urandom_range(4097, 8191);
				default: w = $urandom_range(1, 8);
			endcase
			case ($urandom_range(9))
				0:       h = 0;
				1:       h = 8191;
				default: h = $urandom_range(1, 6);
			endcase
			case ($urandom_range(9))
				0:       d = 8191;
				1:       d = 4096;
				default: d = $urandom_range(0, 8);
			endcase
			program_regs(pick_tone(), pick_tone(), pick_tone(), int'(pick_byte()),
				int'(pick_byte()), d, w, h);
			n = $urandom_range(20, 80);
			quiet = (phases == 12);
			if (quiet)
				n = 150;
			if (phases == 9) begin
				hold_pending = 1;
				n = 80;
			end
			random_pixels(n);
			sent += n;
			drain();
		end
		quiet = 0;

		repeat (20) @(posedge clk);
		$display("checked %0d result beats, %0d complete images, over %0d register settings",
			results_seen, images_seen, phases);
		$display("incl. size clamps, mid-image resizes, bush rows and a %0d-cycle output stall",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
